// File: rtl/core/xeu_pkg.sv
package xeu_pkg;

    localparam int NUM_ENT  = 6;
    localparam int HOLD_MAX = 4;
    localparam int NBSP_IDX = 5;
    localparam int MAX_OUT  = 6;
    localparam int Q_DEPTH  = 4;

    localparam logic [7:0] CH_AMP    = 8'h26;
    localparam logic [7:0] CH_QUOT   = 8'h22;
    localparam logic [7:0] CH_APOS   = 8'h27;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] NBSP_LEAD = 8'hC2;
    localparam logic [7:0] NBSP_CHAR = 8'hA0;

    // candidate masks loaded when '&' opens an entity
    localparam logic [NUM_ENT-1:0] CAND_ALL     = 6'h3F;
    localparam logic [NUM_ENT-1:0] CAND_NO_NBSP = 6'h1F;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } t_in_word;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
    } t_out_word;

    // one front-end word: the bytes a single input word expands to
    typedef struct packed {
        logic [2:0]             cnt;
        logic [MAX_OUT-1:0][7:0] bytes;
        logic                   last;
    } t_cmd;

    // entity text after the '&', lower case; zero past the end
    function automatic logic [7:0] ent_text(input logic [2:0] k, input logic [2:0] pos);
        logic [7:0] c;
        c = 8'h00;
        case (k)
            3'd0: case (pos)
                3'd0: c = "a"; 3'd1: c = "m"; 3'd2: c = "p"; 3'd3: c = CH_SEMI;
                default: c = 8'h00;
            endcase
            3'd1: case (pos)
                3'd0: c = "q"; 3'd1: c = "u"; 3'd2: c = "o"; 3'd3: c = "t";
                3'd4: c = CH_SEMI;
                default: c = 8'h00;
            endcase
            3'd2: case (pos)
                3'd0: c = "a"; 3'd1: c = "p"; 3'd2: c = "o"; 3'd3: c = "s";
                3'd4: c = CH_SEMI;
                default: c = 8'h00;
            endcase
            3'd3: case (pos)
                3'd0: c = "l"; 3'd1: c = "t"; 3'd2: c = CH_SEMI;
                default: c = 8'h00;
            endcase
            3'd4: case (pos)
                3'd0: c = "g"; 3'd1: c = "t"; 3'd2: c = CH_SEMI;
                default: c = 8'h00;
            endcase
            3'd5: case (pos)
                3'd0: c = "n"; 3'd1: c = "b"; 3'd2: c = "s"; 3'd3: c = "p";
                3'd4: c = CH_SEMI;
                default: c = 8'h00;
            endcase
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [2:0] ent_len(input logic [2:0] k);
        logic [2:0] n;
        case (k)
            3'd0:    n = 3'd4;
            3'd3:    n = 3'd3;
            3'd4:    n = 3'd3;
            default: n = 3'd5;
        endcase
        return n;
    endfunction

    function automatic logic [7:0] ent_char(input logic [2:0] k);
        logic [7:0] c;
        case (k)
            3'd0:    c = CH_AMP;
            3'd1:    c = CH_QUOT;
            3'd2:    c = CH_APOS;
            3'd3:    c = CH_LT;
            3'd4:    c = CH_GT;
            default: c = NBSP_CHAR;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] b);
        logic [7:0] r;
        r = b;
        if (b inside {["A":"Z"]}) r = b + 8'd32;
        return r;
    endfunction

endpackage

// File: rtl/core/xml_entity_unescape.sv
// The bytes of an input word pass through the queue and then the output register to o_data.
// Throughput: one input word per cycle while the queue is not full and each
// word yields at most one byte; a word that yields k bytes (flush up to 6) goes
// out byte by byte; the QUEUE_DEPTH-entry queue between front and back absorbs them.
// Reset (i_rst_n low, synchronous) empties the queue, drops any pending entity,
// clears o_valid and sets r_nbsp_en to 1.
module xml_entity_unescape
    import xeu_pkg::*;
#(
    parameter int QUEUE_DEPTH = Q_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_we,
    input  logic      i_cfg_wdata,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_in_word  i_data,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_word o_data
);

    logic full;
    logic empty;
    logic push;
    logic pop;
    t_cmd cmd;
    t_cmd head;

    xeu_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (i_valid),
        .i_data      (i_data),
        .i_full      (full),
        .o_push      (push),
        .o_cmd       (cmd)
    );

    xeu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_head  (head)
    );

    xeu_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_head  (head),
        .o_pop   (pop),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

    assign o_stall = full;

endmodule

// File: rtl/core/xeu_front.sv
module xeu_front
    import xeu_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_cfg_we,
    input  logic     i_cfg_wdata,
    input  logic     i_valid,
    input  t_in_word i_data,
    input  logic     i_full,
    output logic     o_push,
    output t_cmd     o_cmd
);

    logic                r_nbsp_en;
    logic                r_in_entity;
    logic [2:0]          r_held_cnt;
    logic [NUM_ENT-1:0]  r_cand;
    logic [7:0]          r_held [HOLD_MAX];

    logic                n_in_entity;
    logic [2:0]          n_held_cnt;
    logic [NUM_ENT-1:0]  n_cand;

    logic                accept;
    logic                hold_we;
    logic                do_fresh;
    logic [7:0]          lb;
    logic [NUM_ENT-1:0]  keep;
    logic                done_hit;
    logic [2:0]          done_idx;
    logic [2:0]          pos_b;
    t_cmd                cmd;

    assign accept = i_valid && !i_full;
    assign lb     = to_lower(i_data.in_byte);

    always_comb begin
        keep     = '0;
        done_hit = 1'b0;
        done_idx = '0;
        for (int k = 0; k < NUM_ENT; k++) begin
            if (r_cand[k] && r_held_cnt < ent_len(3'(k))
                && ent_text(3'(k), r_held_cnt) == lb) begin
                keep[k] = 1'b1;
                if (ent_len(3'(k)) == r_held_cnt + 3'd1) begin
                    done_hit = 1'b1;
                    done_idx = 3'(k);
                end
            end
        end
    end

    always_comb begin
        n_in_entity = r_in_entity;
        n_held_cnt  = r_held_cnt;
        n_cand      = r_cand;
        hold_we     = 1'b0;
        do_fresh    = 1'b0;
        cmd         = '0;
        cmd.last    = i_data.in_last;
        // current byte goes after '&' and the held bytes when flushing
        pos_b       = r_in_entity ? r_held_cnt + 3'd1 : 3'd0;
        if (accept) begin
            cmd.bytes[0]   = CH_AMP;
            cmd.bytes[4:1] = {r_held[3], r_held[2], r_held[1], r_held[0]};
            if (!r_in_entity) begin
                do_fresh = 1'b1;
            end else if (done_hit) begin
                if (done_idx == 3'(NBSP_IDX)) begin
                    cmd.bytes[0] = NBSP_LEAD;
                    cmd.bytes[1] = NBSP_CHAR;
                    cmd.cnt      = 3'd2;
                end else begin
                    cmd.bytes[0] = ent_char(done_idx);
                    cmd.cnt      = 3'd1;
                end
                n_in_entity = 1'b0;
                n_held_cnt  = '0;
                n_cand      = '0;
            end else if (|keep && r_held_cnt < 3'(HOLD_MAX)) begin
                hold_we    = 1'b1;
                n_held_cnt = r_held_cnt + 3'd1;
                n_cand     = keep;
                if (i_data.in_last) begin
                    cmd.bytes[pos_b] = i_data.in_byte;
                    cmd.cnt          = pos_b + 3'd1;
                end
            end else begin
                cmd.cnt     = r_held_cnt + 3'd1;
                n_in_entity = 1'b0;
                n_held_cnt  = '0;
                n_cand      = '0;
                do_fresh    = 1'b1;
            end

            if (do_fresh) begin
                if (i_data.in_byte == CH_AMP && !i_data.in_last) begin
                    n_in_entity = 1'b1;
                    n_held_cnt  = '0;
                    n_cand      = r_nbsp_en ? CAND_ALL : CAND_NO_NBSP;
                end else begin
                    cmd.bytes[pos_b] = i_data.in_byte;
                    cmd.cnt          = pos_b + 3'd1;
                end
            end

            if (i_data.in_last) begin
                n_in_entity = 1'b0;
                n_held_cnt  = '0;
                n_cand      = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nbsp_en   <= 1'b1;
            r_in_entity <= 1'b0;
            r_held_cnt  <= '0;
            r_cand      <= '0;
        end else begin
            if (i_cfg_we) r_nbsp_en <= i_cfg_wdata;
            r_in_entity <= n_in_entity;
            r_held_cnt  <= n_held_cnt;
            r_cand      <= n_cand;
        end
    end

    always_ff @(posedge i_clk) begin
        if (hold_we) r_held[r_held_cnt[1:0]] <= i_data.in_byte;
    end

    assign o_push = accept && (cmd.cnt != 3'd0);
    assign o_cmd  = cmd;

endmodule

// File: rtl/core/xeu_queue.sv
module xeu_queue
    import xeu_pkg::*;
#(
    parameter int DEPTH = Q_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output logic o_full,
    output logic o_empty,
    output t_cmd o_head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd          r_mem [DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [CW-1:0] r_cnt;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= ptr_inc(r_wr);
            if (i_pop)  r_rd <= ptr_inc(r_rd);
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + CW'(1);
                2'b01:   r_cnt <= r_cnt - CW'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_cmd;
    end

endmodule

// File: rtl/core/xeu_back.sv
module xeu_back
    import xeu_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_empty,
    input  t_cmd      i_head,
    output logic      o_pop,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_word o_data
);

    logic       r_valid;
    t_out_word  r_data;
    logic [2:0] r_idx;
    logic       load;
    logic       tail;

    assign load  = !r_valid || !i_stall;
    assign tail  = (r_idx == i_head.cnt - 3'd1);
    assign o_pop = load && !i_empty && tail;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (load) begin
            r_valid <= !i_empty;
            if (!i_empty) r_idx <= tail ? 3'd0 : r_idx + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && !i_empty) begin
            r_data.out_byte <= i_head.bytes[r_idx];
            r_data.out_last <= i_head.last && tail;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// File: rtl/core/xeu_checker.sv
module xeu_props
    import xeu_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_valid,
    input logic      o_stall,
    input logic      o_valid,
    input logic      i_stall,
    input t_out_word o_data
);

    // reset empties the output register
    a_rst_out: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("o_valid set after reset");

    // reset empties the queue, so input is open again
    a_rst_stall: assert property (@(posedge i_clk) !i_rst_n |=> !o_stall)
        else $error("o_stall set after reset");

    // the queue only fills on an accepted word
    a_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_stall) |-> $past(i_valid && !o_stall))
        else $error("o_stall rose without an accepted word");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data))
        else $error("stalled output word changed");

endmodule

bind xml_entity_unescape xeu_props u_chk (.*);

// File: test/xeu_checker.sv
module xeu_checker
    import xeu_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_we,
    input  logic      i_cfg_wdata,
    input  logic      i_in_valid,
    input  logic      i_in_stall,
    input  t_in_word  i_in_word,
    input  logic      i_out_valid,
    input  logic      i_out_stall,
    input  t_out_word i_out_word,
    output int        o_pending,
    output int        o_fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [NUM_ENT-1:0][7:0] REPLACEMENT =
        {NBSP_CHAR, CH_GT, CH_LT, CH_APOS, CH_QUOT, CH_AMP};

    string entity_names [NUM_ENT] = '{"amp;", "quot;", "apos;", "lt;", "gt;", "nbsp;"};

    logic               nbsp_on = 1'b1;
    logic               open_ent = 1'b0;
    int                 n_held = 0;
    logic [7:0]         held [HOLD_MAX];
    logic [NUM_ENT-1:0] live = '0;
    logic [7:0]         produced [$];
    t_out_word          unescaped_q [$];
    int                 fail_count = 0;

    task automatic report(input string msg);
        $display("%0t ns: %s", $time, msg);
        fail_count++;
    endtask

    function automatic void close_entity();
        open_ent = 1'b0;
        n_held   = 0;
        live     = '0;
    endfunction

    // '&' opens an entity unless it ends the text; nbsp is a candidate only when enabled
    function automatic void take_fresh(input logic [7:0] b, input logic last);
        if (b == CH_AMP && !last) begin
            open_ent = 1'b1;
            n_held   = 0;
            live     = nbsp_on ? CAND_ALL : CAND_NO_NBSP;
        end else begin
            produced.push_back(b);
        end
    endfunction

    function automatic void flush_literal();
        int i;
        produced.push_back(CH_AMP);
        for (i = 0; i < n_held; i++) produced.push_back(held[i]);
        close_entity();
    endfunction

    function automatic void unescape_word(input logic [7:0] b, input logic last);
        logic [7:0]         lb;
        logic [7:0]         ch;
        logic [NUM_ENT-1:0] keep;
        int                 hit;
        int                 k;
        int                 i;
        t_out_word          w;
        produced.delete();
        if (!open_ent) begin
            take_fresh(b, last);
        end else begin
            lb   = (b >= "A" && b <= "Z") ? b + 8'd32 : b;
            keep = '0;
            hit  = -1;
            for (k = 0; k < NUM_ENT; k++) begin
                if (live[k] && n_held < entity_names[k].len()) begin
                    ch = entity_names[k][n_held];
                    if (ch == lb) begin
                        keep[k] = 1'b1;
                        if (entity_names[k].len() == n_held + 1) hit = k;
                    end
                end
            end
            if (hit >= 0) begin
                if (hit == NBSP_IDX) produced.push_back(NBSP_LEAD);
                produced.push_back(REPLACEMENT[hit]);
                close_entity();
            end else if (keep != '0 && n_held < HOLD_MAX) begin
                held[n_held] = b;
                n_held++;
                live = keep;
                if (last) flush_literal();
            end else begin
                flush_literal();
                take_fresh(b, last);
            end
        end
        if (last) close_entity();
        for (i = 0; i < produced.size(); i++) begin
            w.out_byte = produced[i];
            w.out_last = last && (i == produced.size() - 1);
            unescaped_q.push_back(w);
        end
    endfunction

    always @(posedge i_clk) begin
        t_out_word want;
        if (!i_rst_n) begin
            nbsp_on = 1'b1;
            close_entity();
            unescaped_q.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (unescaped_q.size() == 0) begin
                    report($sformatf("unexpected word: byte %02h last %0b",
                                     i_out_word.out_byte, i_out_word.out_last));
                end else begin
                    want = unescaped_q.pop_front();
                    if (i_out_word.out_byte !== want.out_byte)
                        report($sformatf("out_byte %02h, expected %02h",
                                         i_out_word.out_byte, want.out_byte));
                    if (i_out_word.out_last !== want.out_last)
                        report($sformatf("out_last %0b, expected %0b (byte %02h)",
                                         i_out_word.out_last, want.out_last, want.out_byte));
                end
            end
            if (i_cfg_we) nbsp_on = i_cfg_wdata;
            if (i_in_valid && !i_in_stall)
                unescape_word(i_in_word.in_byte, i_in_word.in_last);
        end
        o_pending    <= unescaped_q.size();
        o_fail_count <= fail_count;
    end

endmodule

// File: test/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import xeu_pkg::*;

    typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HALF, STALL_HEAVY} t_stall_kind;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_wdata = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    t_in_word    in_word = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    t_out_word   out_word;
    int          pending;
    int          fails;

    int          burst_left = 0;
    int          words_sent = 0;
    t_stall_kind stall_kind = STALL_NONE;
    int          stall_run = 0;
    logic [7:0]  text_q [$];
    string       entity_names [NUM_ENT] = '{"amp;", "quot;", "apos;", "lt;", "gt;", "nbsp;"};

    xml_entity_unescape dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_valid     (in_valid),
        .o_stall     (in_stall),
        .i_data      (in_word),
        .o_valid     (out_valid),
        .i_stall     (out_stall),
        .o_data      (out_word)
    );

    xeu_checker u_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_word    (in_word),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_word   (out_word),
        .o_pending    (pending),
        .o_fail_count (fails)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // receiver: switches at random between stall densities
    always @(posedge clk) begin
        if (stall_run == 0) begin
            stall_kind = t_stall_kind'($urandom_range(0, 3));
            stall_run  = $urandom_range(10, 60);
        end else begin
            stall_run--;
        end
        case (stall_kind)
            STALL_NONE:  out_stall <= 1'b0;
            STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
            STALL_HALF:  out_stall <= ($urandom_range(0, 1) == 1);
            default:     out_stall <= ($urandom_range(0, 9) < 8);
        endcase
    end

    task automatic send_word(input logic [7:0] b, input logic last);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        in_word  <= '{in_byte: b, in_last: last};
        @(posedge clk);
        while (in_stall) @(posedge clk);
        words_sent++;
    endtask

    task automatic send_text(input logic ends);
        int i;
        for (i = 0; i < text_q.size(); i++)
            send_word(text_q[i], ends && (i == text_q.size() - 1));
        text_q.delete();
    endtask

    function automatic void append(input string s);
        int i;
        for (i = 0; i < s.len(); i++) text_q.push_back(s[i]);
    endfunction

    function automatic logic [7:0] mixcase(input logic [7:0] c);
        if (c >= "a" && c <= "z" && $urandom_range(0, 1) == 1) return c - 8'd32;
        return c;
    endfunction

    task automatic drain();
        in_valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_nbsp(input logic v);
        drain();
        cfg_wdata <= v;
        cfg_we    <= 1'b1;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // whole entities in random case for half the tokens, some cut short, some stray '&' and raw bytes
    task automatic random_text();
        int    n_tok;
        int    t;
        int    i;
        int    kind;
        int    cut;
        string name;
        n_tok = $urandom_range(1, 8);
        for (t = 0; t < n_tok; t++) begin
            kind = $urandom_range(0, 19);
            name = entity_names[$urandom_range(0, NUM_ENT - 1)];
            if (kind < 10) begin
                text_q.push_back(CH_AMP);
                for (i = 0; i < name.len(); i++) text_q.push_back(mixcase(name[i]));
            end else if (kind < 14) begin
                cut = $urandom_range(0, name.len() - 1);
                text_q.push_back(CH_AMP);
                for (i = 0; i < cut; i++) text_q.push_back(mixcase(name[i]));
                if ($urandom_range(0, 1) == 1) text_q.push_back(8'($urandom_range(0, 255)));
            end else if (kind < 16) begin
                text_q.push_back(CH_AMP);
            end else begin
                text_q.push_back(8'($urandom_range(0, 255)));
            end
        end
        send_text(1'b1);
    endtask

    initial begin
        int phase;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // entity completed by the last word of the text
        append("&GT;");
        send_text(1'b1);
        // three held, then a mismatch; extreme byte values around it
        text_q.push_back(8'h00);
        append("&quo");
        text_q.push_back(8'hFF);
        send_text(1'b0);
        // second '&' breaks the first and ends the text alone
        append("&&");
        send_text(1'b1);
        // nbsp enable is taken when '&' arrives, not when the entity completes
        append("&nbs");
        send_text(1'b0);
        write_nbsp(1'b0);
        append("p;");
        send_text(1'b0);
        // nbsp disabled: literal; then the text ends inside an entity
        append("&NbSp;&ap");
        send_text(1'b1);

        for (phase = 0; phase < 4; phase++) begin
            write_nbsp(phase[0] ? 1'b0 : 1'b1);
            while (words_sent < 27 + (phase + 1) * 86) random_text();
        end

        drain();
        repeat (20) @(posedge clk);
        if (fails == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

// File: xml_entity_unescape.f
rtl/core/xeu_pkg.sv
rtl/core/xeu_front.sv
rtl/core/xeu_queue.sv
rtl/core/xeu_back.sv
rtl/core/xml_entity_unescape.sv
rtl/core/xeu_checker.sv
test/xeu_checker.sv
test/testbench.sv
